// ----- rtl/bclk_pkg.sv -----
// bclk_pkg: shared types and codes for the button click classifier
// used by bclk_step and button_click_classifier_unit, no dependencies
package bclk_pkg;

  localparam int unsigned CountW   = 8;
  localparam int unsigned TicksW   = 32;
  localparam int unsigned LimitW   = 16;
  localparam int unsigned CfgIdxW  = 1;
  localparam logic [CountW-1:0] CountMax = '1;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SHORT_LIMIT = 1'b0,
    REG_MULTI_WINDOW = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    OP_TICK  = 1'b0,
    OP_QUERY = 1'b1
  } opcode_e;

  typedef struct packed {
    opcode_e             opcode;
    logic                pin_pressed;
    logic [TicksW-1:0]   now_ticks;
    logic [CountW-1:0]   wanted_presses;
  } in_item_t;

  typedef struct packed {
    logic                is_pressed;
    logic                new_press;
    logic                new_release;
    logic                short_click;
    logic                long_click;
    logic [TicksW-1:0]   hold_ticks;
    logic [TicksW-1:0]   release_ticks;
    logic [CountW-1:0]   press_count;
    logic                query_hit;
  } out_item_t;

  typedef struct packed {
    logic                level;
    logic [TicksW-1:0]   press_stamp;
    logic [TicksW-1:0]   release_stamp;
    logic [TicksW-1:0]   hold_len;
    logic [TicksW-1:0]   release_len;
    logic [CountW-1:0]   multi_count;
  } btn_state_t;

  typedef struct packed {
    logic [LimitW-1:0]   short_limit;
    logic [LimitW-1:0]   multi_window;
  } btn_cfg_t;

endpackage

// ----- rtl/bclk_step.sv -----
// bclk_step: next-state and result logic for one beat
// depends on bclk_pkg
module bclk_step import bclk_pkg::*; (
  input  in_item_t   item_i,
  input  btn_state_t state_i,
  input  btn_cfg_t   cfg_i,
  output btn_state_t state_o,
  output out_item_t  result_o
);

  logic              is_tick;
  logic              edge_press;
  logic              edge_release;
  logic              level_n;
  logic [TicksW-1:0] press_stamp_n;
  logic [TicksW-1:0] release_stamp_n;
  logic [TicksW-1:0] rel_diff;
  logic              rel_ok;
  logic              win_clear;
  logic [CountW-1:0] cnt_base;
  logic              hit;
  logic              is_short;

  always_comb begin
    is_tick         = (item_i.opcode == OP_TICK);
    edge_press      = is_tick & item_i.pin_pressed & ~state_i.level;
    edge_release    = is_tick & ~item_i.pin_pressed & state_i.level;
    level_n         = is_tick ? item_i.pin_pressed : state_i.level;
    press_stamp_n   = edge_press ? item_i.now_ticks : state_i.press_stamp;
    release_stamp_n = edge_release ? item_i.now_ticks : state_i.release_stamp;
    rel_diff        = item_i.now_ticks - release_stamp_n;
    rel_ok          = is_tick & ~level_n & (item_i.now_ticks >= release_stamp_n);
    win_clear       = rel_ok & (rel_diff > {{(TicksW-LimitW){1'b0}}, cfg_i.multi_window});
    hit             = ~is_tick & (state_i.multi_count >= item_i.wanted_presses);
    // hold length is never touched on a release tick, so old value classifies
    is_short        = (state_i.hold_len <= {{(TicksW-LimitW){1'b0}}, cfg_i.short_limit});

    state_o               = state_i;
    state_o.level         = level_n;
    state_o.press_stamp   = press_stamp_n;
    state_o.release_stamp = release_stamp_n;
    if (is_tick && level_n && (item_i.now_ticks >= press_stamp_n)) begin
      state_o.hold_len = item_i.now_ticks - press_stamp_n;
    end
    if (rel_ok) begin
      state_o.release_len = rel_diff;
    end

    cnt_base = (win_clear || hit) ? '0 : state_i.multi_count;
    if (edge_release && (cnt_base != CountMax)) begin
      state_o.multi_count = cnt_base + CountW'(1);
    end else begin
      state_o.multi_count = cnt_base;
    end

    result_o.is_pressed    = level_n;
    result_o.new_press     = edge_press;
    result_o.new_release   = edge_release;
    result_o.short_click   = edge_release & is_short;
    result_o.long_click    = edge_release & ~is_short;
    result_o.hold_ticks    = state_o.hold_len;
    result_o.release_ticks = state_o.release_len;
    result_o.press_count   = state_o.multi_count;
    result_o.query_hit     = hit;
  end

endmodule

// ----- rtl/button_click_classifier_unit.sv -----
// button_click_classifier_unit: top level, state, config and output buffering
// depends on bclk_pkg and bclk_step
//
// Classifies button activity from a stream of beats. A tick beat carries the
// sampled level and the current time; a query beat asks whether at least the
// given number of consecutive presses was seen, and clears the count on a hit.
// Every input beat yields exactly one result beat. A beat is worked out
// combinationally by one subtract-and-compare path from the state registers,
// so one beat is taken per clock while input is not stalled. Its result sits
// in an output register backed by a one-entry skid register, so
// input is stalled only when both are full. Configuration writes take effect
// on the next beat and must only be issued while the block is idle.
module button_click_classifier_unit import bclk_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration write port
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [LimitW-1:0]   cfg_wdata_i,
  // input channel
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  in_item_t            in_data_i,
  // result channel
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output out_item_t           out_data_o
);

  btn_cfg_t   cfg_q;
  btn_state_t state_q, state_d;
  out_item_t  result_d;
  out_item_t  out_q;
  out_item_t  skid_q;
  logic       out_valid_q;
  logic       skid_valid_q;
  logic       in_acc;
  logic       out_take;

  // input stalls only when the skid entry holds a waiting result
  assign in_stall_o = skid_valid_q;
  assign in_acc     = in_valid_i & ~skid_valid_q;
  assign out_take   = out_valid_q & ~out_stall_i;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.short_limit  <= LimitW'(400);
      cfg_q.multi_window <= LimitW'(300);
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_SHORT_LIMIT:  cfg_q.short_limit  <= cfg_wdata_i;
        REG_MULTI_WINDOW: cfg_q.multi_window <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  bclk_step u_step (
    .item_i   (in_data_i),
    .state_i  (state_q),
    .cfg_i    (cfg_q),
    .state_o  (state_d),
    .result_o (result_d)
  );

  // button state advances on every accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (in_acc) begin
      state_q <= state_d;
    end
  end

  // output register plus skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_take) begin
        skid_valid_q <= 1'b0;
      end
    end else if (in_acc) begin
      if (out_valid_q && !out_take) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_q <= 1'b0;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_take) begin
        out_q <= skid_q;
      end
    end else if (in_acc) begin
      if (out_valid_q && !out_take) begin
        skid_q <= result_d;
      end else begin
        out_q <= result_d;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // a waiting skid beat always sits behind a full output register
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid entry valid with empty output register");

  // a release is classified exactly one way
  a_click_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((out_q.short_click || out_q.long_click) == out_q.new_release
                     && !(out_q.short_click && out_q.long_click)))
    else $error("click classification inconsistent");

  // a press edge leaves the button held, a release edge leaves it released
  a_edge_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (!out_q.new_press || out_q.is_pressed)
                    && (!out_q.new_release || !out_q.is_pressed))
    else $error("edge flag disagrees with level");

  // a query hit clears the count
  a_hit_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.query_hit) |-> (out_q.press_count == '0))
    else $error("query hit left count nonzero");

endmodule
